### sv/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned CAP_W     = 25;
	localparam int unsigned REMAIN_W  = 24;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 25'd131072;
	localparam logic [CAP_W-1:0] CAP_CEIL  = 25'd16777216;

	// Word index of each register on the configuration port.
	localparam logic REG_FRAME_CAPACITY = 1'b0;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       first_of_frame;
		logic       last_of_frame;
		logic       frame_too_large;
	} lpfd_result_t;

endpackage

### sv/length_prefixed_frame_deframer_unit.sv
// An accepted byte waits in the input register; its result goes to the result register.
// Throughput: one byte per cycle; a byte is consumed whenever the result register is free.
// The state update and length compare of a byte are combinational between the registers.
// Reset (arst_n low, asynchronous) empties both registers, returns to header collection,
// and sets the frame capacity to 131072 bytes. Only reset leaves the sticky error state.
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Splits a byte stream into frames with a 4-byte little-endian length header,
// flags first and last payload bytes, and reports an oversized frame once.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    payload_byte,
	output logic                          first_of_frame,
	output logic                          last_of_frame,
	output logic                          frame_too_large,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpfd_pkg::APB_AW-1:0]   paddr,
	input  logic [lpfd_pkg::APB_DW-1:0]   pwdata,
	output logic [lpfd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	import lpfd_pkg::*;

	logic             take;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             res_valid;
	lpfd_result_t     res;
	lpfd_result_t     res_s2;
	logic [CAP_W-1:0] cap_q;
	logic             reg_sel;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1] == REG_FRAME_CAPACITY);
	assign prdata  = reg_sel ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign take = valid_s1 & out_free;

	lpfd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.take      (take),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	lpfd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.byte_s1        (byte_s1),
		.frame_capacity (cap_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	lpfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign payload_byte    = res_s2.payload_byte;
	assign first_of_frame  = res_s2.first_of_frame;
	assign last_of_frame   = res_s2.last_of_frame;
	assign frame_too_large = res_s2.frame_too_large;

endmodule

### sv/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module lpfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;

	// The stage can refill in the same cycle that its byte moves on.
	assign in_stall = valid_s1 & ~take;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

### sv/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core
// Deframing state machine: gathers the length header, counts payload bytes
// and decides on the result of each consumed byte.
// ----------------------------------------------------------------------------
module lpfd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [7:0]                  byte_s1,
	input  logic [lpfd_pkg::CAP_W-1:0]  frame_capacity,
	output logic                        res_valid,
	output lpfd_pkg::lpfd_result_t      res
);

	import lpfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [1:0]          hdr_cnt_q, hdr_cnt_d;
	logic [23:0]         len_q, len_d;
	logic [REMAIN_W-1:0] remain_q, remain_d;
	logic                start_q, start_d;

	logic [31:0]         full_len;
	logic [CAP_W-1:0]    cap_eff;
	logic                too_big;
	logic                last;

	// The fourth header byte is combined here, never stored.
	assign full_len = {byte_s1, len_q};
	assign cap_eff  = (frame_capacity > CAP_CEIL) ? CAP_CEIL : frame_capacity;
	assign too_big  = ({1'b0, full_len} + 33'(HDR_BYTES)) > {8'b0, cap_eff};
	assign last     = (remain_q <= REMAIN_W'(1));

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		remain_d  = remain_q;
		start_d   = start_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_HEADER: begin
				hdr_cnt_d = hdr_cnt_q + 2'd1;
				case (hdr_cnt_q)
					2'd0: len_d[7:0]   = byte_s1;
					2'd1: len_d[15:8]  = byte_s1;
					2'd2: len_d[23:16] = byte_s1;
					default: begin
						len_d = '0;
						if (full_len != 32'd0) begin
							if (too_big) begin
								phase_d             = PH_ERROR;
								res_valid           = 1'b1;
								res.frame_too_large = 1'b1;
							end else begin
								phase_d  = PH_PAYLOAD;
								remain_d = full_len[REMAIN_W-1:0];
								start_d  = 1'b1;
							end
						end
					end
				endcase
			end
			PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.payload_byte   = byte_s1;
				res.first_of_frame = start_q;
				res.last_of_frame  = last;
				if (last) begin
					phase_d  = PH_HEADER;
					remain_d = '0;
					start_d  = 1'b1;
				end else begin
					remain_d = remain_q - REMAIN_W'(1);
					start_d  = 1'b0;
				end
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
		if (!take) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			remain_q  <= '0;
			start_q   <= 1'b1;
		end else if (take) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			remain_q  <= remain_d;
			start_q   <= start_d;
		end
	end

endmodule

### sv/lpfd_out_stage.sv
// ----------------------------------------------------------------------------
// lpfd_out_stage
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module lpfd_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  lpfd_pkg::lpfd_result_t res,
	output logic                   out_free,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lpfd_pkg::lpfd_result_t res_s2
);

	import lpfd_pkg::*;

	// Free when empty or when the held result transfers this cycle.
	assign out_free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

### sv/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lpfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       first_of_frame,
	input logic       last_of_frame,
	input logic       frame_too_large,
	input logic       pready
);

	logic out_xfer;
	logic err_seen_q;
	logic in_frame_q;

	assign out_xfer = out_valid & ~out_stall;

	// Tracks whether an error has been delivered and whether a frame is open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			in_frame_q <= 1'b0;
		end else if (out_xfer) begin
			if (frame_too_large) begin
				err_seen_q <= 1'b1;
			end
			if (first_of_frame && !last_of_frame) begin
				in_frame_q <= 1'b1;
			end else if (last_of_frame) begin
				in_frame_q <= 1'b0;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(first_of_frame) && $stable(last_of_frame)
			&& $stable(frame_too_large))
		else $error("stalled result changed");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |-> !out_valid)
		else $error("result after frame-too-large");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_too_large |->
			payload_byte == 8'd0 && !first_of_frame && !last_of_frame)
		else $error("error result carries payload flags");

	a_frame_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_frame_q |-> !first_of_frame && !frame_too_large)
		else $error("new frame or error inside an open frame");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind length_prefixed_frame_deframer_unit lpfd_checker u_lpfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.payload_byte    (payload_byte),
	.first_of_frame  (first_of_frame),
	.last_of_frame   (last_of_frame),
	.frame_too_large (frame_too_large),
	.pready          (pready)
);
